// ===== src/scpd_pkg.sv =====
`timescale 1ns / 1ps

package scpd_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned LEN_BYTES    = HEADER_BYTES - 1;
    localparam int unsigned MIN_PKT_LEN  = 2;

    localparam logic [15:0] MAX_PKT_LEN_RESET = 16'd4096;
    localparam logic [15:0] PAYLOAD_CAP_RESET = 16'd4096;

    localparam logic CFG_MAX_PKT_LEN = 1'b0;
    localparam logic CFG_PAYLOAD_CAP = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PADDING,
        PH_DEAD
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_LENGTH,
        ERR_CAPACITY
    } t_err;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        packet_end;
        logic [15:0] payload_length;
        t_err        error_code;
    } t_result;

endpackage

// ===== src/ssh_cleartext_packet_deframer_top.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_rx_byte
// out       output     o_out_valid / i_out_stall o_payload_byte, o_byte_valid,
//                                                o_packet_end, o_payload_length,
//                                                o_error_code
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the output does not stall; a taken word passes
// from the input register through header/counter logic into the result register
// header and padding words other than the last give no output word
// synchronous active-low reset; config returns to 4096 / 4096, no clearing pass
// an output stall holds the result register and backs up through the input register
`timescale 1ns / 1ps

module ssh_cleartext_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_packet_end,
    output logic [15:0] o_payload_length,
    output logic [1:0]  o_error_code
);
    import scpd_pkg::*;

    logic       w_advance;
    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;

    scpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .i_take  (w_advance),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    scpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_in_valid && w_advance),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    scpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_ready     (w_advance),
        .i_res_valid (w_res_valid && w_in_valid),
        .i_res       (w_res),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (w_out_res)
    );

    assign o_payload_byte   = w_out_res.payload_byte;
    assign o_byte_valid     = w_out_res.byte_valid;
    assign o_packet_end     = w_out_res.packet_end;
    assign o_payload_length = w_out_res.payload_length;
    assign o_error_code     = w_out_res.error_code;

endmodule

// ===== src/scpd_in_reg.sv =====
`timescale 1ns / 1ps

module scpd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import scpd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== src/scpd_core.sv =====
`timescale 1ns / 1ps

module scpd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    output logic                 o_res_valid,
    output scpd_pkg::t_result    o_res
);
    import scpd_pkg::*;

    logic [15:0] r_max_len;
    logic [15:0] r_cap;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_hc,     n_hc;
    logic [31:0] r_len,    n_len;
    logic [7:0]  r_pad,    n_pad;
    logic [15:0] r_br,     n_br;
    logic [15:0] r_pc,     n_pc;

    logic        w_hdr_last;
    logic        w_len_bad;
    logic [16:0] w_diff;
    logic        w_too_big;
    logic [15:0] w_dec;
    logic        w_dec_zero;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_PKT_LEN_RESET;
            r_cap     <= PAYLOAD_CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_PKT_LEN: r_max_len <= i_cfg_data;
                CFG_PAYLOAD_CAP: r_cap     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header checks
    assign w_hdr_last = (r_hc == 3'(LEN_BYTES));
    assign w_len_bad  = (r_len < 32'(MIN_PKT_LEN)) || (r_len > {16'd0, r_max_len});
    assign w_diff     = {1'b0, r_len[15:0]} - {9'd0, i_byte} - 17'd1;
    assign w_too_big  = w_diff[16] || (w_diff[15:0] > r_cap);
    assign w_dec      = r_br - 16'd1;
    assign w_dec_zero = (w_dec == 16'd0);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hc    = r_hc;
        n_len   = r_len;
        n_pad   = r_pad;
        n_br    = r_br;
        n_pc    = r_pc;
        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    if (!w_hdr_last) begin
                        n_len = {r_len[23:0], i_byte};
                        n_hc  = r_hc + 3'd1;
                    end else begin
                        n_pad = i_byte;
                        n_hc  = 3'd0;
                        if (w_len_bad || w_too_big) begin
                            n_phase = PH_DEAD;
                        end else begin
                            n_pc = w_diff[15:0];
                            if (w_diff[15:0] != 16'd0) begin
                                n_br    = w_diff[15:0];
                                n_phase = PH_PAYLOAD;
                            end else if (i_byte != 8'd0) begin
                                n_br    = {8'd0, i_byte};
                                n_phase = PH_PADDING;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_br = w_dec;
                    if (w_dec_zero) begin
                        if (r_pad == 8'd0) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_br    = {8'd0, r_pad};
                            n_phase = PH_PADDING;
                        end
                    end
                end
                PH_PADDING: begin
                    n_br = w_dec;
                    if (w_dec_zero) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: ;
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    if (w_hdr_last) begin
                        if (w_len_bad) begin
                            o_res_valid      = 1'b1;
                            o_res.error_code = ERR_LENGTH;
                        end else if (w_too_big) begin
                            o_res_valid      = 1'b1;
                            o_res.error_code = ERR_CAPACITY;
                        end else if (w_diff[15:0] == 16'd0 && i_byte == 8'd0) begin
                            o_res_valid      = 1'b1;
                            o_res.packet_end = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                    o_res.byte_valid   = 1'b1;
                    if (w_dec_zero && r_pad == 8'd0) begin
                        o_res.packet_end     = 1'b1;
                        o_res.payload_length = r_pc;
                    end
                end
                PH_PADDING: begin
                    if (w_dec_zero) begin
                        o_res_valid          = 1'b1;
                        o_res.packet_end     = 1'b1;
                        o_res.payload_length = r_pc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hc    <= 3'd0;
            r_len   <= 32'd0;
            r_pad   <= 8'd0;
            r_br    <= 16'd0;
            r_pc    <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_len   <= n_len;
            r_pad   <= n_pad;
            r_br    <= n_br;
            r_pc    <= n_pc;
        end
    end

    a_dead_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DEAD |=> r_phase == PH_DEAD)
        else $error("left dead phase without reset");

    a_err_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.error_code != ERR_NONE |=> r_phase == PH_DEAD)
        else $error("error reported but block still running");

    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.packet_end |=> r_phase == PH_HEADER && r_hc == 3'd0)
        else $error("packet end not followed by header");

    a_hc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= 3'(LEN_BYTES))
        else $error("header count out of range");

endmodule

// ===== src/scpd_out_reg.sv =====
`timescale 1ns / 1ps

module scpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_ready,
    input  logic              i_res_valid,
    input  scpd_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_stall,
    output scpd_pkg::t_result o_res
);
    import scpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
